// ===== rtl/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
package u8d_pkg;

	localparam int unsigned CP_W = 21;

	localparam logic [CP_W-1:0] REPL_CP  = 21'h00FFFD;
	localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;
	localparam logic [CP_W-1:0] MIN_CP2  = 21'h000080;
	localparam logic [CP_W-1:0] MIN_CP3  = 21'h000800;
	localparam logic [CP_W-1:0] MIN_CP4  = 21'h010000;

	// Expected sequence length codes.
	localparam logic [2:0] SEQ_NONE = 3'd0;
	localparam logic [2:0] SEQ_TWO  = 3'd2;
	localparam logic [2:0] SEQ_THREE = 3'd3;
	localparam logic [2:0] SEQ_FOUR = 3'd4;

	// One queued job: cnt results, all but the last are U+FFFD errors,
	// the last one carries tail_cp and tail_err.
	typedef struct packed {
		logic [2:0]      cnt;
		logic [CP_W-1:0] tail_cp;
		logic            tail_err;
	} u8d_job_t;

endpackage

// ===== rtl/u8d_front.sv =====
// Front part: takes bytes, tracks the pending sequence and classifies each byte into a job.
module u8d_front import u8d_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    in_byte,
	input  logic          stream_end,
	output logic          push,
	output u8d_job_t      job
);

	logic [CP_W-1:0] acc_q, nxt_acc, acc6;
	logic [2:0]      len_q, nxt_len;
	logic [1:0]      ct_q, nxt_ct, ct1;
	logic [2:0]      flush_cnt;
	logic            lead_cnt;
	logic            lead_go;
	logic            is_cont;
	logic            bad;
	logic [CP_W-1:0] tail_cp;
	logic            tail_err;

	always_comb begin
		nxt_acc   = acc_q;
		nxt_len   = len_q;
		nxt_ct    = ct_q;
		flush_cnt = 3'd0;
		lead_cnt  = 1'b0;
		lead_go   = 1'b1;
		tail_cp   = REPL_CP;
		tail_err  = 1'b1;
		is_cont   = (in_byte[7:6] == 2'b10);
		acc6      = {acc_q[CP_W-7:0], in_byte[5:0]};
		ct1       = ct_q + 2'd1;
		bad       = 1'b0;

		if (len_q != SEQ_NONE) begin
			if (is_cont) begin
				lead_go = 1'b0;
				if (({1'b0, ct1} + 3'd1) >= len_q) begin
					bad = ((len_q == SEQ_TWO) && (acc6 < MIN_CP2)) ||
					      ((len_q == SEQ_THREE) && (acc6 < MIN_CP3)) ||
					      ((len_q == SEQ_FOUR) && (acc6 < MIN_CP4)) ||
					      ((acc6 >= SURR_LO) && (acc6 <= SURR_HI)) ||
					      (acc6 > CP_MAX);
					lead_cnt = 1'b1;
					tail_cp  = bad ? REPL_CP : acc6;
					tail_err = bad;
					nxt_acc  = '0;
					nxt_len  = SEQ_NONE;
					nxt_ct   = 2'd0;
				end else if (stream_end) begin
					flush_cnt = {1'b0, ct1} + 3'd1;
				end else begin
					nxt_acc = acc6;
					nxt_ct  = ct1;
				end
			end else begin
				// The sequence is broken: every byte taken so far becomes U+FFFD.
				flush_cnt = {1'b0, ct_q} + 3'd1;
				nxt_acc   = '0;
				nxt_len   = SEQ_NONE;
				nxt_ct    = 2'd0;
			end
		end

		if (lead_go) begin
			if (in_byte inside {[8'h00:8'h7F]}) begin
				lead_cnt = 1'b1;
				tail_cp  = {13'd0, in_byte};
				tail_err = 1'b0;
			end else if (in_byte inside {[8'hC0:8'hDF]}) begin
				nxt_acc  = {16'd0, in_byte[4:0]};
				nxt_len  = SEQ_TWO;
				nxt_ct   = 2'd0;
				lead_cnt = stream_end;
			end else if (in_byte inside {[8'hE0:8'hEF]}) begin
				nxt_acc  = {17'd0, in_byte[3:0]};
				nxt_len  = SEQ_THREE;
				nxt_ct   = 2'd0;
				lead_cnt = stream_end;
			end else if (in_byte inside {[8'hF0:8'hF7]}) begin
				nxt_acc  = {18'd0, in_byte[2:0]};
				nxt_len  = SEQ_FOUR;
				nxt_ct   = 2'd0;
				lead_cnt = stream_end;
			end else begin
				lead_cnt = 1'b1;
			end
		end

		if (stream_end) begin
			nxt_acc = '0;
			nxt_len = SEQ_NONE;
			nxt_ct  = 2'd0;
		end
	end

	assign job.cnt      = flush_cnt + {2'd0, lead_cnt};
	assign job.tail_cp  = tail_cp;
	assign job.tail_err = tail_err;
	assign push         = accept && (job.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			len_q <= SEQ_NONE;
			ct_q  <= 2'd0;
		end else if (accept) begin
			acc_q <= nxt_acc;
			len_q <= nxt_len;
			ct_q  <= nxt_ct;
		end
	end

endmodule

// ===== rtl/u8d_queue.sv =====
// Short job queue between the front and back parts.
module u8d_queue import u8d_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  u8d_job_t push_job,
	input  logic     pop,
	output u8d_job_t head_job,
	output logic     full,
	output logic     empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	u8d_job_t       mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/u8d_back.sv =====
// Back part: expands each job into code points, one per cycle while cp_stall is low, into the output register.
module u8d_back import u8d_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  u8d_job_t        head_job,
	output logic            pop,
	output logic            cp_valid,
	input  logic            cp_stall,
	output logic [CP_W-1:0] code_point,
	output logic            was_error,
	output logic            run_last
);

	logic [1:0]      idx_q;
	logic            valid_q;
	logic [CP_W-1:0] cp_q;
	logic            err_q;
	logic            last_q;
	logic            emit;
	logic            job_last;

	assign emit     = !empty && (!valid_q || !cp_stall);
	assign job_last = (({1'b0, idx_q} + 3'd1) == head_job.cnt);
	assign pop      = emit && job_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (emit) begin
				valid_q <= 1'b1;
				idx_q   <= job_last ? 2'd0 : idx_q + 2'd1;
			end else if (!cp_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			cp_q   <= job_last ? head_job.tail_cp : REPL_CP;
			err_q  <= job_last ? head_job.tail_err : 1'b1;
			last_q <= job_last;
		end
	end

	assign cp_valid   = valid_q;
	assign code_point = cp_q;
	assign was_error  = err_q;
	assign run_last   = last_q;

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder: front part, job queue and back part.
//
//  Channel  | Handshake                | Payload
//  ---------+--------------------------+------------------------------------
//  byte in  | byte_valid / byte_stall  | in_byte[7:0], stream_end
//  cp out   | cp_valid / cp_stall      | code_point[20:0], was_error, run_last
//
// A byte is taken in every cycle while the job queue has room; the front part
// updates the pending sequence in that same cycle. The back part delivers one
// code point per cycle from the head job while cp_stall is low; a byte gives up
// to four code points (more than one only on malformed input), and the
// sustained rate is one byte per cycle when each byte gives at most one code
// point and cp_stall stays low. A byte's first code point passes through the
// job queue and the output register. After reset no sequence is pending and
// the queue is empty, so byte_stall is low at once; byte_stall rises only while
// the queue is full, and cp_stall holds the output register.
module utf8_stream_decoder import u8d_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	output logic            byte_stall,
	input  logic [7:0]      in_byte,
	input  logic            stream_end,
	output logic            cp_valid,
	input  logic            cp_stall,
	output logic [CP_W-1:0] code_point,
	output logic            was_error,
	output logic            run_last
);

	logic     accept;
	logic     q_push;
	logic     q_pop;
	logic     q_full;
	logic     q_empty;
	u8d_job_t new_job;
	u8d_job_t head_job;

	// A byte transaction completes whenever the queue can take its job.
	assign byte_stall = q_full;
	assign accept     = byte_valid && !q_full;

	// The front part works out every result a byte causes; only jobs that
	// carry at least one code point enter the queue.
	u8d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_byte    (in_byte),
		.stream_end (stream_end),
		.push       (q_push),
		.job        (new_job)
	);

	u8d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (new_job),
		.pop      (q_pop),
		.head_job (head_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	// The back part expands the head job: leading replacements first, then
	// the tail result marked as the last one of its byte.
	u8d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (q_empty),
		.head_job   (head_job),
		.pop        (q_pop),
		.cp_valid   (cp_valid),
		.cp_stall   (cp_stall),
		.code_point (code_point),
		.was_error  (was_error),
		.run_last   (run_last)
	);

`ifndef ASSERT_OFF
	// The queue is never written while full.
	assert property (@(posedge clk) disable iff (!arst_n) !(q_push && q_full))
		else $error("job queue overflow");

	// A job is never taken from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("job queue underflow");

	// A byte's burst of code points is not broken by a gap.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cp_valid && !cp_stall && !run_last) |=> cp_valid)
		else $error("gap inside a burst of results");

	// A code point delivered without error is a Unicode scalar value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cp_valid && !was_error) |->
		((code_point <= CP_MAX) && ((code_point < SURR_LO) || (code_point > SURR_HI))))
		else $error("invalid scalar value delivered without error");
`endif

endmodule

// ===== tb/utf8_decode_checker.sv =====
// Checker for the UTF-8 stream decoder: predicts code points from accepted bytes and compares.
`timescale 1ns / 1ps

module utf8_decode_checker import u8d_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	input  logic            byte_stall,
	input  logic [7:0]      in_byte,
	input  logic            stream_end,
	input  logic            cp_valid,
	input  logic            cp_stall,
	input  logic [CP_W-1:0] code_point,
	input  logic            was_error,
	input  logic            run_last,
	output int unsigned     mismatches,
	output int unsigned     outstanding
);

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            err;
		logic            last;
	} decoded_cp_t;

	decoded_cp_t expected_cps[$];

	// Predicted copy of the pending sequence.
	logic [CP_W-1:0] acc;
	logic [2:0]      seq_len;
	logic [1:0]      conts;

	// Code points produced by the byte being predicted.
	decoded_cp_t step_buf[4];
	int          step_count;

	function automatic void clear_seq();
		acc = '0;
		seq_len = SEQ_NONE;
		conts = 2'd0;
	endfunction

	function automatic void emit_cp(input logic [CP_W-1:0] cp, input logic err);
		if (step_count < 4) begin
			step_buf[step_count] = '{cp: cp, err: err, last: 1'b0};
			step_count = step_count + 1;
		end
	endfunction

	// The lead and every continuation taken so far each become a replacement.
	function automatic void flush_seq();
		int i;
		for (i = 0; i <= int'(conts); i++)
			emit_cp(REPL_CP, 1'b1);
		clear_seq();
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic fin);
		logic        taken;
		logic        bad;
		decoded_cp_t e;
		int          i;
		taken = 1'b0;
		step_count = 0;
		if (seq_len != SEQ_NONE) begin
			if (b[7:6] == 2'b10) begin
				acc = {acc[CP_W-7:0], b[5:0]};
				conts = conts + 2'd1;
				if ({1'b0, conts} + 3'd1 >= seq_len) begin
					bad = (seq_len == SEQ_TWO && acc < MIN_CP2) ||
						(seq_len == SEQ_THREE && acc < MIN_CP3) ||
						(seq_len == SEQ_FOUR && acc < MIN_CP4) ||
						(acc >= SURR_LO && acc <= SURR_HI) || acc > CP_MAX;
					if (bad)
						emit_cp(REPL_CP, 1'b1);
					else
						emit_cp(acc, 1'b0);
					clear_seq();
				end else if (fin) begin
					flush_seq();
				end
				taken = 1'b1;
			end else begin
				// Broken sequence: flush it, then treat this byte as a new lead.
				flush_seq();
			end
		end
		if (!taken) begin
			if (b[7] == 1'b0) begin
				emit_cp({13'd0, b}, 1'b0);
			end else if (b[7:5] == 3'b110) begin
				acc = {16'd0, b[4:0]};
				seq_len = SEQ_TWO;
				conts = 2'd0;
			end else if (b[7:4] == 4'b1110) begin
				acc = {17'd0, b[3:0]};
				seq_len = SEQ_THREE;
				conts = 2'd0;
			end else if (b[7:3] == 5'b11110) begin
				acc = {18'd0, b[2:0]};
				seq_len = SEQ_FOUR;
				conts = 2'd0;
			end else begin
				emit_cp(REPL_CP, 1'b1);
			end
			if (fin && seq_len != SEQ_NONE)
				flush_seq();
		end
		if (fin)
			clear_seq();
		for (i = 0; i < step_count; i++) begin
			e = step_buf[i];
			e.last = (i == step_count - 1);
			expected_cps.push_back(e);
		end
	endtask

	function automatic void flag_mismatch(input decoded_cp_t want, input logic have_want);
		mismatches = mismatches + 1;
		if (mismatches <= 10) begin
			if (have_want)
				$display("%0t: code point check failed: expected cp %h err %b last %b, got cp %h err %b last %b",
					$realtime, want.cp, want.err, want.last, code_point, was_error, run_last);
			else
				$display("%0t: unexpected code point: got cp %h err %b last %b",
					$realtime, code_point, was_error, run_last);
		end
	endfunction

	initial mismatches = 0;

	always @(posedge clk or negedge arst_n) begin
		decoded_cp_t want;
		if (!arst_n) begin
			clear_seq();
			expected_cps.delete();
			outstanding <= 0;
		end else begin
			// Results are compared before the byte of this edge is predicted, since a
			// byte can never produce a code point in the cycle of its own transaction.
			if (cp_valid && !cp_stall) begin
				if (expected_cps.size() == 0) begin
					flag_mismatch('0, 1'b0);
				end else begin
					want = expected_cps.pop_front();
					if (code_point !== want.cp || was_error !== want.err || run_last !== want.last)
						flag_mismatch(want, 1'b1);
				end
			end
			if (byte_valid && !byte_stall)
				decode_byte(in_byte, stream_end);
			outstanding <= expected_cps.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the UTF-8 stream decoder testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
	import u8d_pkg::*;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            byte_valid = 1'b0;
	logic            byte_stall;
	logic [7:0]      in_byte = 8'h00;
	logic            stream_end = 1'b0;
	logic            cp_valid;
	logic            cp_stall = 1'b0;
	logic [CP_W-1:0] code_point;
	logic            was_error;
	logic            run_last;

	int unsigned mismatches;
	int unsigned outstanding;

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int idle_pct = 0;
	int stall_pct = 0;
	int bytes_sent = 0;

	// Directed bytes; bit 8 carries stream_end. They walk through the ASCII extremes,
	// the smallest and largest two-byte forms, an overlong two-byte form, a
	// surrogate, a value above the Unicode range, a lone continuation, an invalid
	// lead, a four-byte sequence broken after two continuations by an ASCII byte
	// (three replacements, then A), a stream that ends inside a sequence, an F5 lead
	// arriving together with the end of the stream, and an ASCII byte closing a stream.
	logic [8:0] directed_bytes [0:24] = '{
		9'h000, 9'h07F,
		9'h0C2, 9'h080,
		9'h0DF, 9'h0BF,
		9'h0C0, 9'h080,
		9'h0ED, 9'h0A0, 9'h080,
		9'h0F4, 9'h090, 9'h080, 9'h080,
		9'h080,
		9'h0FF,
		9'h0F0, 9'h090, 9'h080, 9'h041,
		9'h0E2, 9'h182,
		9'h1F5,
		9'h141
	};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The receiver stalls at random; a stall percentage of zero never stalls.
	always @(posedge clk) begin
		cp_stall <= ($urandom_range(99) < stall_pct);
	end

	utf8_stream_decoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.in_byte    (in_byte),
		.stream_end (stream_end),
		.cp_valid   (cp_valid),
		.cp_stall   (cp_stall),
		.code_point (code_point),
		.was_error  (was_error),
		.run_last   (run_last)
	);

	utf8_decode_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.in_byte     (in_byte),
		.stream_end  (stream_end),
		.cp_valid    (cp_valid),
		.cp_stall    (cp_stall),
		.code_point  (code_point),
		.was_error   (was_error),
		.run_last    (run_last),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Offers one byte and returns in the time step of the edge at which its
	// transaction completes. Idle cycles are inserted beforehand at random; valid
	// is only ever lowered in a step where it is not also raised, and the payload
	// holds still for as long as the decoder stalls it.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		in_byte <= b;
		stream_end <= fin;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		bytes_sent = bytes_sent + 1;
	endtask

	// Sends one unit of the random stream. Most units are sequences of the right
	// shape with random content, which reaches overlong forms, surrogates and
	// values beyond the Unicode range as well as good code points. Some are cut
	// short or have a continuation replaced by an arbitrary byte, and the rest are
	// lone random bytes. The end of the stream is flagged now and then on any byte,
	// so it also lands in the middle of sequences.
	task automatic send_random_unit();
		logic [7:0] unit [4];
		int         len;
		int         kind;
		int         pos;
		int         i;
		kind = $urandom_range(9);
		if (kind == 9) begin
			send_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
		end else begin
			len = $urandom_range(1, 4);
			case (len)
				1: unit[0] = 8'($urandom_range(8'h7F));
				2: unit[0] = 8'($urandom_range(8'hC0, 8'hDF));
				3: unit[0] = 8'($urandom_range(8'hE0, 8'hEF));
				default: unit[0] = 8'($urandom_range(8'hF0, 8'hF7));
			endcase
			for (i = 1; i < 4; i++)
				unit[i] = 8'($urandom_range(8'h80, 8'hBF));
			if (kind >= 7 && len > 1) begin
				pos = $urandom_range(1, len - 1);
				if (kind == 7)
					len = pos;
				else
					unit[pos] = 8'($urandom_range(255));
			end
			for (i = 0; i < len; i++)
				send_byte(unit[i], $urandom_range(15) == 0);
		end
	endtask

	initial begin
		int phase;
		int goal;
		int i;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// The directed bytes go through with neither side idling.
		for (i = 0; i < 25; i++)
			send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);

		// Random stream in four idling phases: none, sender idle, receiver
		// stalling, and both together at a lighter rate.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 86;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 86;
				end
				default: begin
					idle_pct = 30;
					stall_pct = 30;
				end
			endcase
			goal = bytes_sent + 24;
			while (bytes_sent < goal)
				send_random_unit();
		end

		// Stimulus done: drain the remaining code points, then allow for the
		// decoder's latency so that any stray result is still caught.
		byte_valid <= 1'b0;
		stall_pct = 0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run, including every byte giving
	// four replacements behind a heavily stalled receiver.
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/u8d_pkg.sv
rtl/u8d_front.sv
rtl/u8d_queue.sv
rtl/u8d_back.sv
rtl/utf8_stream_decoder.sv
tb/utf8_decode_checker.sv
tb/testbench.sv
